// ----- sv/cgad_pkg.sv -----
// ---------------------------------------------------------------------------
// cgad_pkg
// Shared types and constants of the CGA palette error-diffusion ditherer.
// ---------------------------------------------------------------------------
`default_nettype none

package cgad_pkg;

   // pixel component width
   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_NONE = 8'h00;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALT_MODE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHROMA_ALT   = 2'd3;

   localparam int LINE_WIDTH_W   = 11;
   localparam int FRAME_HEIGHT_W = 16;
   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

   // luma scale: 2*(r+g+b)*one / 765, rounded
   localparam int LUMA_DIV  = 765;
   localparam int LUMA_BIAS = 382;

   // sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_L,
      S_DIV_C,
      S_RD_CUR,
      S_RD_PREV,
      S_CALC,
      S_WR_PREV,
      S_WR_CUR
   } state_type;

endpackage

`default_nettype wire

// ----- sv/cgad_if.sv -----
// ---------------------------------------------------------------------------
// cgad channel interfaces
// Valid/ready channels for input pixels and palette pixels.
// ---------------------------------------------------------------------------
`default_nettype none

interface cgad_pix_if;
   logic                         valid;
   logic                         ready;
   logic [cgad_pkg::PIX_W-1:0]   red_in;
   logic [cgad_pkg::PIX_W-1:0]   green_in;
   logic [cgad_pkg::PIX_W-1:0]   blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface cgad_pal_if;
   logic                         valid;
   logic                         ready;
   logic [cgad_pkg::PIX_W-1:0]   red_out;
   logic [cgad_pkg::PIX_W-1:0]   green_out;
   logic [cgad_pkg::PIX_W-1:0]   blue_out;
   logic                         frame_end;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output frame_end, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input frame_end, output ready);
endinterface

`default_nettype wire

// ----- sv/cgad_ram.sv -----
// ---------------------------------------------------------------------------
// cgad_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module cgad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/cga_palette_error_diffusion_dither.sv -----
// ---------------------------------------------------------------------------
// cga_palette_error_diffusion_dither
// Floyd-Steinberg ditherer of RGB pixels onto a four-colour CGA palette.
// ---------------------------------------------------------------------------
// Usage:
//  - req carries RGB pixels in raster order; rsp returns, per pixel, one of
//    black, white, magenta, cyan (blue off in alt_mode); frame_end on last.
//  - csr_we/csr_index/csr_wdata write line_width, frame_height, alt_mode and
//    chroma_alt_mode; write them only while no pixel is in flight.
//  - One pixel is processed at a time. Luma is scaled by a reciprocal
//    multiply; a restoring divider then produces the chroma ratio one
//    quotient bit per cycle, ERROR_FRAC_BITS+2 bits, skipped when the
//    chroma denominator is zero. The line buffer is then read and written
//    in RD_CUR, RD_PREV, CALC, WR_PREV and WR_CUR; rsp valid rises at the
//    edge of the last buffer write.
//  - Reset is synchronous. After it the error line buffer is cleared, one
//    entry a cycle, all MAX_WIDTH entries, before req ready first rises.
//  - A stalled rsp holds its result; the next pixel is still accepted and
//    worked on, and waits at its final write until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module cga_palette_error_diffusion_dither #(
   parameter int MAX_WIDTH       = 1024,
   parameter int ERROR_FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   cgad_pix_if.sink                           req,
   cgad_pal_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [cgad_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cgad_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int F   = ERROR_FRAC_BITS;
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int EW  = F + 4;          // stored error
   localparam int VW  = F + 6;          // corrected value and sums
   localparam int LW  = F + 2;          // luma / chroma value
   localparam int QW  = F + 2;          // quotient bits
   localparam int NW  = F + 11;         // dividend
   localparam int DW  = 11;             // divisor
   localparam int CW  = $clog2(QW);
   localparam int RW  = 2 * EW;
   localparam int KL  = NW + 10;        // luma reciprocal shift
   localparam int MW  = F + 12;         // luma reciprocal width
   localparam int PW  = NW + MW;        // luma product width

   localparam logic signed [VW-1:0] ONE_V  = VW'(64'sd1 <<< F);
   localparam logic signed [VW-1:0] HALF_V = VW'(64'sd1 <<< (F - 1));
   localparam logic signed [LW-1:0] ONE_L  = LW'(64'sd1 <<< F);
   localparam logic signed [VW-1:0] ERR_HI = VW'((64'sd1 <<< (F + 3)) - 64'sd1);
   localparam logic signed [VW-1:0] ERR_LO = VW'(-(64'sd1 <<< (F + 3)));
   // ceil(2^KL / 765): exact floor division for every dividend below 2^NW
   localparam logic [MW-1:0] LUMA_RECIP =
      MW'(((64'd1 << KL) + 64'(cgad_pkg::LUMA_DIV) - 64'd1) / 64'(cgad_pkg::LUMA_DIV));

   // saturate to the stored error range
   function automatic logic signed [EW-1:0] sat_err(input logic signed [VW-1:0] x);
      logic signed [EW-1:0] r;
      if (x > ERR_HI) begin
         r = EW'(ERR_HI);
      end else if (x < ERR_LO) begin
         r = EW'(ERR_LO);
      end else begin
         r = EW'(x);
      end
      return r;
   endfunction

   // |e|*w/16 rounded half up, sign restored
   function automatic logic signed [VW-1:0] share(input logic signed [EW-1:0] e,
                                                  input logic [2:0] w);
      logic [EW-1:0]          mag;
      logic [EW+2:0]          prod;
      logic signed [VW-1:0]   q;
      mag  = e[EW-1] ? EW'(-e) : EW'(e);
      prod = (EW+3)'(mag) * (EW+3)'(w);
      q    = VW'((prod + (EW+3)'(8)) >> 4);
      return e[EW-1] ? -q : q;
   endfunction

   // configuration registers
   logic [cgad_pkg::LINE_WIDTH_W-1:0]   line_width_ff;
   logic [cgad_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic                                alt_ff;
   logic                                calt_ff;

   // sequencer and position
   cgad_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff;
   logic [AW-1:0]       cc_ff, cc_in;
   logic [15:0]         rc_ff, rc_in;
   logic [AW-1:0]       j_ff;
   logic [15:0]         row_ff;
   logic                lastc_ff, lastr_ff;

   // geometry of the current item
   logic [31:0]         lw32;
   logic [AW-1:0]       wm1;
   logic [15:0]         hm1;
   logic [AW-1:0]       j_cur;
   logic [15:0]         row_cur;

   // pixel and divider
   logic [cgad_pkg::PIX_W-1:0] r_ff, g_ff, b_ff;
   logic [DW-1:0]       rem_ff, div_ff;
   logic [QW-1:0]       quo_ff, quo_next;
   logic [CW-1:0]       cnt_ff;
   logic [DW:0]         trial;
   logic                ge;
   logic                div_last;
   logic [9:0]          lsum;
   logic [NW-1:0]       lnum, lnum_ff;
   logic [PW-1:0]       lprod;
   logic [QW-1:0]       lquo;
   logic [8:0]          rm2, gc2, dmag;
   logic [9:0]          den;
   logic                dneg;
   logic [NW-1:0]       cnum;
   logic signed [LW-1:0] luma_ff, chroma_ff;

   // error path
   logic signed [EW-1:0] cur_l_ff, cur_c_ff, prev_l_ff, prev_c_ff;
   logic signed [EW-1:0] right_l_ff, right_c_ff, below_l_ff, below_c_ff;
   logic signed [EW-1:0] e_l_ff, e_c_ff, ncur_l_ff, ncur_c_ff;
   logic                 pos_l_ff, neg_l_ff, pos_c_ff;
   logic signed [VW-1:0] v_l, v_c, lsub;
   logic                 pos_l, neg_l, pos_c;
   logic signed [EW-1:0] pl_new, pc_new;
   logic signed [EW-1:0] rd_l, rd_c;

   // memory ports
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [RW-1:0]       ram_wdata, ram_rdata;

   // output register
   logic                      rsp_valid_ff;
   logic [cgad_pkg::PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic                      fend_ff;
   logic                      out_free;
   logic [cgad_pkg::PIX_W-1:0] blue_lvl;

   // error line buffer: {chroma, luma} per column
   cgad_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_l = ram_rdata[EW-1:0];
   assign rd_c = ram_rdata[RW-1:EW];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= cgad_pkg::LINE_WIDTH_RST;
         frame_height_ff <= cgad_pkg::FRAME_HEIGHT_RST;
         alt_ff          <= 1'b0;
         calt_ff         <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            cgad_pkg::CSR_LINE_WIDTH:   line_width_ff <= csr_wdata[cgad_pkg::LINE_WIDTH_W-1:0];
            cgad_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            cgad_pkg::CSR_ALT_MODE:     alt_ff <= csr_wdata[0];
            cgad_pkg::CSR_CHROMA_ALT:   calt_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   always_comb begin
      lw32 = 32'(line_width_ff);
      if (line_width_ff == '0) begin
         wm1 = '0;
      end else if (lw32 > 32'(MAX_WIDTH)) begin
         wm1 = AW'(MAX_WIDTH - 1);
      end else begin
         wm1 = AW'(lw32 - 32'd1);
      end
      hm1     = (frame_height_ff == '0) ? 16'd0 : frame_height_ff - 16'd1;
      j_cur   = (cc_ff > wm1) ? wm1 : cc_ff;
      row_cur = (rc_ff > hm1) ? hm1 : rc_ff;
   end

   // dividends, luma scale and divider step
   always_comb begin
      lsum = 10'(req.red_in) + 10'(req.green_in) + 10'(req.blue_in);
      lnum = (NW'(lsum) << (F + 1)) + NW'(cgad_pkg::LUMA_BIAS);
      lprod = PW'(lnum_ff) * PW'(LUMA_RECIP);
      lquo  = lprod[PW-1:KL];
      if (!calt_ff) begin
         rm2 = alt_ff ? {r_ff, 1'b0} : 9'(r_ff) + 9'(b_ff);
         gc2 = alt_ff ? 9'(g_ff) + 9'(b_ff) : {g_ff, 1'b0};
      end else begin
         rm2 = alt_ff ? 9'(r_ff) + 9'(b_ff) : 9'(r_ff) + 9'(g_ff);
         gc2 = alt_ff ? {g_ff, 1'b0} : {b_ff, 1'b0};
      end
      den      = 10'(rm2) + 10'(gc2);
      dneg     = gc2 < rm2;
      dmag     = dneg ? rm2 - gc2 : gc2 - rm2;
      cnum     = (NW'(dmag) << (F + 1)) + NW'(den);
      trial    = {rem_ff, quo_ff[QW-1]};
      ge       = trial >= {1'b0, div_ff};
      quo_next = {quo_ff[QW-2:0], ge};
      div_last = cnt_ff == CW'(QW - 1);
   end

   // quantise the corrected values
   always_comb begin
      v_l   = VW'(luma_ff) + VW'(cur_l_ff) + VW'(right_l_ff);
      v_c   = VW'(chroma_ff) + VW'(cur_c_ff) + VW'(right_c_ff);
      pos_l = v_l >= HALF_V;
      neg_l = v_l <= -HALF_V;
      pos_c = !v_c[VW-1];
      lsub  = pos_l ? ONE_V : (neg_l ? -ONE_V : '0);
      pl_new = sat_err(VW'(prev_l_ff) + share(e_l_ff, 3'd3));
      pc_new = sat_err(VW'(prev_c_ff) + share(e_c_ff, 3'd3));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cgad_pkg::S_CLEAR:   if (clr_ff == AW'(MAX_WIDTH - 1)) state_in = cgad_pkg::S_IDLE;
         cgad_pkg::S_IDLE:    if (req.valid) state_in = cgad_pkg::S_DIV_L;
         cgad_pkg::S_DIV_L:
            state_in = (den == '0) ? cgad_pkg::S_RD_CUR : cgad_pkg::S_DIV_C;
         cgad_pkg::S_DIV_C:   if (div_last) state_in = cgad_pkg::S_RD_CUR;
         cgad_pkg::S_RD_CUR:  state_in = cgad_pkg::S_RD_PREV;
         cgad_pkg::S_RD_PREV: state_in = cgad_pkg::S_CALC;
         cgad_pkg::S_CALC:    state_in = cgad_pkg::S_WR_PREV;
         cgad_pkg::S_WR_PREV: state_in = cgad_pkg::S_WR_CUR;
         cgad_pkg::S_WR_CUR:  if (out_free) state_in = cgad_pkg::S_IDLE;
         default:             state_in = cgad_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs: handshake and buffer accesses
   always_comb begin
      out_free  = !rsp_valid_ff || rsp.ready;
      req.ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = j_ff;
      ram_wdata = {ncur_c_ff, ncur_l_ff};
      ram_raddr = j_ff - AW'(1);
      unique case (state_ff)
         cgad_pkg::S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         cgad_pkg::S_IDLE:   req.ready = 1'b1;
         cgad_pkg::S_RD_CUR: ram_raddr = j_ff;
         cgad_pkg::S_WR_PREV: begin
            ram_we    = (j_ff != '0) && !lastr_ff;
            ram_waddr = j_ff - AW'(1);
            ram_wdata = {pc_new, pl_new};
         end
         cgad_pkg::S_WR_CUR: ram_we = out_free;
         default: ;
      endcase
   end

   // next position
   always_comb begin
      if (lastc_ff) begin
         cc_in = '0;
         rc_in = lastr_ff ? 16'd0 : row_ff + 16'd1;
      end else begin
         cc_in = j_ff + AW'(1);
         rc_in = row_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cgad_pkg::S_CLEAR;
         clr_ff       <= '0;
         cc_ff        <= '0;
         rc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         right_l_ff   <= '0;
         right_c_ff   <= '0;
         below_l_ff   <= '0;
         below_c_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == cgad_pkg::S_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (state_ff == cgad_pkg::S_WR_PREV) begin
            right_l_ff <= lastc_ff ? '0 : sat_err(share(e_l_ff, 3'd7));
            right_c_ff <= lastc_ff ? '0 : sat_err(share(e_c_ff, 3'd7));
            below_l_ff <= (lastc_ff || lastr_ff) ? '0 : sat_err(share(e_l_ff, 3'd1));
            below_c_ff <= (lastc_ff || lastr_ff) ? '0 : sat_err(share(e_c_ff, 3'd1));
         end
         if (state_ff == cgad_pkg::S_WR_CUR && out_free) begin
            cc_ff        <= cc_in;
            rc_ff        <= rc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         cgad_pkg::S_IDLE: begin
            r_ff     <= req.red_in;
            g_ff     <= req.green_in;
            b_ff     <= req.blue_in;
            j_ff     <= j_cur;
            row_ff   <= row_cur;
            lastc_ff <= j_cur == wm1;
            lastr_ff <= row_cur == hm1;
            lnum_ff  <= lnum;
         end
         // luma by reciprocal, then load the chroma divider
         cgad_pkg::S_DIV_L: begin
            luma_ff   <= $signed(lquo) - ONE_L;
            chroma_ff <= '0;
            rem_ff    <= DW'(cnum[NW-1:QW]);
            quo_ff    <= cnum[QW-1:0];
            div_ff    <= {den, 1'b0};
            cnt_ff    <= '0;
         end
         cgad_pkg::S_DIV_C: begin
            rem_ff <= ge ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
            quo_ff <= quo_next;
            cnt_ff <= cnt_ff + CW'(1);
            if (div_last) begin
               chroma_ff <= dneg ? -$signed(quo_next) : $signed(quo_next);
            end
         end
         cgad_pkg::S_RD_PREV: begin
            cur_l_ff <= rd_l;
            cur_c_ff <= rd_c;
         end
         cgad_pkg::S_CALC: begin
            prev_l_ff <= rd_l;
            prev_c_ff <= rd_c;
            e_l_ff    <= sat_err(v_l - lsub);
            e_c_ff    <= sat_err(v_c - (pos_c ? ONE_V : -ONE_V));
            pos_l_ff  <= pos_l;
            neg_l_ff  <= neg_l;
            pos_c_ff  <= pos_c;
         end
         cgad_pkg::S_WR_PREV: begin
            ncur_l_ff <= lastr_ff ? '0 : sat_err(VW'(below_l_ff) + share(e_l_ff, 3'd5));
            ncur_c_ff <= lastr_ff ? '0 : sat_err(VW'(below_c_ff) + share(e_c_ff, 3'd5));
         end
         default: ;
      endcase
   end

   // palette output register
   assign blue_lvl = alt_ff ? cgad_pkg::PIX_NONE : cgad_pkg::PIX_FULL;

   always_ff @(posedge clock) begin
      if (state_ff == cgad_pkg::S_WR_CUR && out_free) begin
         fend_ff <= lastc_ff && lastr_ff;
         if (neg_l_ff) begin
            red_ff   <= cgad_pkg::PIX_NONE;
            green_ff <= cgad_pkg::PIX_NONE;
            blue_ff  <= cgad_pkg::PIX_NONE;
         end else if (pos_l_ff) begin
            red_ff   <= cgad_pkg::PIX_FULL;
            green_ff <= cgad_pkg::PIX_FULL;
            blue_ff  <= blue_lvl;
         end else if (!pos_c_ff) begin
            red_ff   <= cgad_pkg::PIX_FULL;
            green_ff <= cgad_pkg::PIX_NONE;
            blue_ff  <= blue_lvl;
         end else begin
            red_ff   <= cgad_pkg::PIX_NONE;
            green_ff <= cgad_pkg::PIX_FULL;
            blue_ff  <= blue_lvl;
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.red_out   = red_ff;
   assign rsp.green_out = green_ff;
   assign rsp.blue_out  = blue_ff;
   assign rsp.frame_end = fend_ff;

   // checks
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == cgad_pkg::S_DIV_L)
      else $error("accepted pixel did not start the divider");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == cgad_pkg::S_DIV_C |-> rem_ff < div_ff)
      else $error("divider remainder out of range");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cgad_pkg::S_WR_CUR))
      else $error("result raised outside the final write");

   a_write_in_row: assert property (@(posedge clock) disable iff (reset)
      ram_we && state_ff != cgad_pkg::S_CLEAR |-> ram_waddr <= wm1)
      else $error("line buffer write beyond the row");

endmodule

`default_nettype wire

// ----- tb/cga_palette_error_diffusion_dither_checker.sv -----
// ---------------------------------------------------------------------------
// cga_palette_error_diffusion_dither_checker
// Watches the pixel and palette channels, predicts each palette pixel with
// its own fixed-point error-diffusion model and compares field by field.
// ---------------------------------------------------------------------------
module cga_palette_error_diffusion_dither_checker #(
   parameter int MAX_WIDTH       = 1024,
   parameter int ERROR_FRAC_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   cgad_pix_if.sink                          req,
   cgad_pal_if.sink                          rsp,
   input  logic                              csr_we,
   input  logic [cgad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cgad_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                fail_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE    = longint'(1) << ERROR_FRAC_BITS;
   localparam longint HALF   = longint'(1) << (ERROR_FRAC_BITS - 1);
   localparam longint ERR_HI = (longint'(1) << (ERROR_FRAC_BITS + 3)) - 1;
   localparam longint ERR_LO = -(longint'(1) << (ERROR_FRAC_BITS + 3));

   typedef struct packed {
      logic [cgad_pkg::PIX_W-1:0] red;
      logic [cgad_pkg::PIX_W-1:0] green;
      logic [cgad_pkg::PIX_W-1:0] blue;
      logic                       frame_end;
   } palette_pixel_type;

   // shadow of configuration and diffusion state
   logic [cgad_pkg::LINE_WIDTH_W-1:0]   width_reg;
   logic [cgad_pkg::FRAME_HEIGHT_W-1:0] height_reg;
   logic                                alt_reg, chroma_alt_reg;
   longint luma_line [MAX_WIDTH];
   longint chroma_line [MAX_WIDTH];
   longint luma_carry, chroma_carry, luma_diag, chroma_diag;
   int unsigned col, row;
   palette_pixel_type palette_queue[$];

   function automatic longint clamp_error(longint v);
      if (v > ERR_HI) return ERR_HI;
      if (v < ERR_LO) return ERR_LO;
      return v;
   endfunction

   // weighted share, rounded half up on the magnitude
   function automatic longint weighted(longint e, longint w);
      longint mag, q;
      mag = e < 0 ? -e : e;
      q = (mag * w + 8) >>> 4;
      return e < 0 ? -q : q;
   endfunction

   task automatic spread(ref longint line[MAX_WIDTH], ref longint carry,
                         ref longint diag, input longint e, input int unsigned j,
                         input bit lastc, input bit lastr);
      carry = lastc ? 0 : clamp_error(weighted(e, 7));
      if (lastr) begin
         line[j] = 0;
         diag = 0;
      end else begin
         if (j > 0) line[j-1] = clamp_error(line[j-1] + weighted(e, 3));
         line[j] = clamp_error(diag + weighted(e, 5));
         diag = lastc ? 0 : clamp_error(weighted(e, 1));
      end
   endtask

   task automatic predict_palette(input logic [cgad_pkg::PIX_W-1:0] r8, g8, b8);
      longint r, g, b, luma, chroma, rm2, gc2, den, d, q, v;
      int unsigned w, h, j, rw;
      bit lastc, lastr;
      int lev_l, lev_c;
      palette_pixel_type p;
      r = r8; g = g8; b = b8;
      w = width_reg == 0 ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
      h = height_reg == 0 ? 1 : height_reg;
      j = col > w - 1 ? w - 1 : col;
      rw = row > h - 1 ? h - 1 : row;
      lastc = (j == w - 1);
      lastr = (rw == h - 1);
      luma = (2 * (r + g + b) * ONE + cgad_pkg::LUMA_BIAS) / cgad_pkg::LUMA_DIV - ONE;
      if (!chroma_alt_reg) begin
         if (!alt_reg) begin rm2 = r + b; gc2 = 2 * g; end
         else begin rm2 = 2 * r; gc2 = g + b; end
      end else begin
         if (!alt_reg) begin rm2 = r + g; gc2 = 2 * b; end
         else begin rm2 = r + b; gc2 = 2 * g; end
      end
      den = rm2 + gc2;
      if (den == 0) begin
         chroma = 0;
      end else begin
         d = gc2 - rm2;
         q = (2 * ((d < 0 ? -d : d) * ONE) + den) / (2 * den);
         chroma = d < 0 ? -q : q;
      end
      v = luma + luma_line[j] + luma_carry;
      lev_l = v >= HALF ? 1 : (v <= -HALF ? -1 : 0);
      spread(luma_line, luma_carry, luma_diag, clamp_error(v - lev_l * ONE),
             j, lastc, lastr);
      v = chroma + chroma_line[j] + chroma_carry;
      lev_c = v >= 0 ? 1 : -1;
      spread(chroma_line, chroma_carry, chroma_diag, clamp_error(v - lev_c * ONE),
             j, lastc, lastr);
      if (lev_l < 0) begin
         p.red = cgad_pkg::PIX_NONE; p.green = cgad_pkg::PIX_NONE;
         p.blue = cgad_pkg::PIX_NONE;
      end else if (lev_l > 0) begin
         p.red = cgad_pkg::PIX_FULL; p.green = cgad_pkg::PIX_FULL;
         p.blue = alt_reg ? cgad_pkg::PIX_NONE : cgad_pkg::PIX_FULL;
      end else if (lev_c < 0) begin
         p.red = cgad_pkg::PIX_FULL; p.green = cgad_pkg::PIX_NONE;
         p.blue = alt_reg ? cgad_pkg::PIX_NONE : cgad_pkg::PIX_FULL;
      end else begin
         p.red = cgad_pkg::PIX_NONE; p.green = cgad_pkg::PIX_FULL;
         p.blue = alt_reg ? cgad_pkg::PIX_NONE : cgad_pkg::PIX_FULL;
      end
      p.frame_end = lastc && lastr;
      palette_queue.push_back(p);
      if (lastc) begin
         col = 0;
         row = lastr ? 0 : rw + 1;
      end else begin
         col = j + 1;
         row = rw;
      end
   endtask

   // model update and comparison at each rising edge
   always @(posedge clock) begin
      palette_pixel_type got, want;
      if (reset) begin
         width_reg <= cgad_pkg::LINE_WIDTH_RST;
         height_reg <= cgad_pkg::FRAME_HEIGHT_RST;
         alt_reg <= 1'b0;
         chroma_alt_reg <= 1'b0;
         for (int k = 0; k < MAX_WIDTH; k++) begin
            luma_line[k] = 0;
            chroma_line[k] = 0;
         end
         luma_carry = 0; chroma_carry = 0; luma_diag = 0; chroma_diag = 0;
         col = 0; row = 0;
         palette_queue.delete();
         pending_count = 0;
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               cgad_pkg::CSR_LINE_WIDTH:
                  width_reg <= csr_wdata[cgad_pkg::LINE_WIDTH_W-1:0];
               cgad_pkg::CSR_FRAME_HEIGHT:
                  height_reg <= csr_wdata[cgad_pkg::FRAME_HEIGHT_W-1:0];
               cgad_pkg::CSR_ALT_MODE:     alt_reg <= csr_wdata[0];
               cgad_pkg::CSR_CHROMA_ALT:   chroma_alt_reg <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.red_out, rsp.green_out, rsp.blue_out, rsp.frame_end};
            if (palette_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected palette transfer %p", got);
            end else begin
               want = palette_queue.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("palette mismatch: expected %p, got %p", want, got);
               end
            end
         end
         if (req.valid && req.ready)
            predict_palette(req.red_in, req.green_in, req.blue_in);
         pending_count = palette_queue.size();
      end
   end
endmodule

// ----- tb/cga_palette_error_diffusion_dither_test.sv -----
// ---------------------------------------------------------------------------
// cga_palette_error_diffusion_dither_test
// Drives pixel frames under several geometries and channel mixes, with random
// gaps and stalls, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module cga_palette_error_diffusion_dither_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH   = 1024;
   localparam int CYCLE_LIMIT = 1_000_000;

   logic                            clock, reset;
   logic                            csr_we;
   logic [cgad_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cgad_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                              fail_count, pending_count;
   int                              cycle_count;
   bit                              hold_off;

   cgad_pix_if pix_ch ();
   cgad_pal_if pal_ch ();

   cga_palette_error_diffusion_dither #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock(clock), .reset(reset), .req(pix_ch.sink), .rsp(pal_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   cga_palette_error_diffusion_dither_checker #(.MAX_WIDTH(MAX_WIDTH)) checker_i (
      .clock(clock), .reset(reset), .req(pix_ch.sink), .rsp(pal_ch.sink),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count));

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver: random stalls per transfer, long hold-off on request
   initial begin
      int gap;
      pal_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            pal_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            pal_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pal_ch.ready <= 1'b1;
         @(posedge clock);
         while (!pal_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_csr(input logic [cgad_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[cgad_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [7:0] r, g, b, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
      if (gap > 0) begin
         pix_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pix_ch.valid <= 1'b1;
      pix_ch.red_in <= r;
      pix_ch.green_in <= g;
      pix_ch.blue_in <= b;
      @(posedge clock);
      while (!pix_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // wait until every palette pixel has come back, then let the block settle
   task automatic drain();
      pix_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_mode(input int width, input int height, input bit alt,
                           input bit calt);
      write_csr(cgad_pkg::CSR_LINE_WIDTH, width);
      write_csr(cgad_pkg::CSR_FRAME_HEIGHT, height);
      write_csr(cgad_pkg::CSR_ALT_MODE, alt);
      write_csr(cgad_pkg::CSR_CHROMA_ALT, calt);
   endtask

   // random pixel: mostly smooth image content, some full-range noise
   task automatic random_pixels(input int count, input bit tight);
      logic [7:0] base;
      for (int k = 0; k < count; k++) begin
         base = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 3) == 0)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), tight);
         else
            send_pixel(base ^ 8'($urandom_range(0, 15)), base ^ 8'($urandom_range(0, 15)),
                       base ^ 8'($urandom_range(0, 15)), tight);
      end
   endtask

   initial begin
      hold_off = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pix_ch.valid = 1'b0;
      pix_ch.red_in = '0;
      pix_ch.green_in = '0;
      pix_ch.blue_in = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: small frame, extremes, zero denominator, each colour mix
      set_mode(3, 2, 0, 0);
      send_pixel(8'h00, 8'h00, 8'h00, 0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 0);
      send_pixel(8'hFF, 8'h00, 8'hFF, 0);
      send_pixel(8'h00, 8'hFF, 8'h00, 0);
      send_pixel(8'h80, 8'h80, 8'h80, 0);
      send_pixel(8'h55, 8'hAA, 8'h55, 0);
      drain();
      set_mode(1, 1, 1, 0);
      send_pixel(8'hFF, 8'h00, 8'h00, 0);
      send_pixel(8'h00, 8'h00, 8'hFF, 0);
      drain();
      set_mode(0, 0, 1, 1);
      send_pixel(8'h7F, 8'h00, 8'h80, 0);
      send_pixel(8'h00, 8'h00, 8'h00, 0);
      drain();
      set_mode(2047, 2, 0, 1);
      send_pixel(8'h00, 8'h00, 8'hFF, 0);
      send_pixel(8'hFF, 8'hFF, 8'h00, 0);
      send_pixel(8'h01, 8'h02, 8'h04, 0);
      drain();
      // shrink size while counters sit past it
      set_mode(2, 1, 0, 0);
      send_pixel(8'h40, 8'hC0, 8'h20, 0);
      send_pixel(8'hFE, 8'h01, 8'h7F, 0);
      drain();

      // random phases under different geometries
      set_mode(7, 9, 0, 0);
      random_pixels(200, 0);
      drain();
      set_mode(16, 65535, 1, 0);
      // sender keeps offering while the receiver holds off
      hold_off = 1'b1;
      random_pixels(300, 1);
      drain();
      set_mode(5, 4, 0, 1);
      random_pixels(200, 0);
      drain();
      set_mode(1, 3, 1, 1);
      random_pixels(200, 0);
      drain();
      set_mode(1024, 1, 0, 0);
      random_pixels(1100, 0);
      drain();
      set_mode(13, 2, 1, 0);
      random_pixels(100, 0);
      drain();

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
